// ----- rtl/abtd_pkg.sv -----
// ----------------------------------------------------------------------------
// abtd_pkg: shared types and constants of the task dispatcher
// Command codes, task kinds, status codes and the cell request struct.
// ----------------------------------------------------------------------------
package abtd_pkg;

  // Sizes of the dispatcher; the stream field widths are built around these.
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_WORKERS = 16;
  localparam int TAG_WIDTH   = 16;

  localparam int KIND_W = 2;
  localparam int AFF_W  = 5;
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REL_ALL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REL_ONE  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BARRIER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOOP    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOOP = 2'd3;

  localparam logic [AFF_W-1:0] AFF_NONE = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_OUT
  } state_t;

  // Control sent along the row of queue cells.
  typedef struct packed {
    logic write;   // load cell at the write slot
    logic take;    // remove entry at the take slot, shift the rest down
  } cell_ctl_t;

endpackage

// ----- rtl/affinity_barrier_task_dispatcher_top.sv -----
// ----------------------------------------------------------------------------
// affinity_barrier_task_dispatcher_top: task dispatcher for worker threads
// Bounded task queue built as a row of cells with affinity search, barrier
// blocking, release flags and wrapping event counters.
// ----------------------------------------------------------------------------
// Sequence: an accepted request goes through a search step that registers the
//   slot and an update step that loads the result register; the result is then
//   shown. No new request is taken until the result handshake completes and
//   the block returns to idle; a held result stalls input.
// Reset (rst, synchronous): queue empty, no barrier, no busy worker, release
//   flags and counters clear, use_affinity 0, worker_count 16.
module affinity_barrier_task_dispatcher_top (
  input  logic         clk,
  input  logic         rst,
  // config port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0: command[3], task_kind[2], task_affinity[5],
  //   task_tag[16], worker[4], zero pad
  input  logic [31:0]  s_tdata,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0: status[2], given_kind[2], given_affinity[5],
  //   given_tag[16], all_done[1], busy_count[5], queue_length[5],
  //   blocked_flag[1], delivered_count[32], completed_count[32],
  //   barrier_count[32], emptied_count[32], zero pad
  output logic [167:0] m_tdata
);

  localparam int QUEUE_DEPTH = abtd_pkg::QUEUE_DEPTH;
  localparam int MAX_WORKERS = abtd_pkg::MAX_WORKERS;
  localparam int TAG_WIDTH   = abtd_pkg::TAG_WIDTH;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = abtd_pkg::KIND_W + abtd_pkg::AFF_W + TAG_WIDTH;
  localparam int BUSY_W = $clog2(MAX_WORKERS + 1);

  abtd_pkg::state_t state, state_next;

  // configuration
  logic       use_affinity;
  logic [4:0] worker_count;

  // latched request
  logic [2:0]           cmd_q;
  logic [1:0]           kind_q;
  logic [4:0]           aff_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [3:0]           worker_q;

  // dispatcher state
  logic [CNT_W-1:0]        entry_count;
  logic [4:0]              blocking_id;
  logic [BUSY_W-1:0]       busy_level;
  logic [MAX_WORKERS-1:0]  release_flags;
  logic [31:0] delivered_total, completed_total, barrier_total, emptied_total;

  // search result register
  logic [IDX_W-1:0] pos_q;

  abtd_pkg::cell_ctl_t   ctl;
  logic [ENT_W-1:0]      slot_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] barrier_flags, match_flags;

  assign s_tready = (state == abtd_pkg::S_IDLE);

  // effective worker count and in-use check
  logic [6:0] active;
  logic       in_use;
  assign active = (7'(worker_count) > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : 7'(worker_count);
  assign in_use = 7'(worker_q) < active;

  // oldest match ahead of the first barrier, within the filled slots; the head slot if none or affinity search is off
  logic [IDX_W-1:0] pos_comb;
  always_comb begin
    logic stop;
    pos_comb = '0;
    stop     = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!stop && CNT_W'(i) < entry_count) begin
        if (barrier_flags[i]) begin
          stop = 1'b1;
        end else if (match_flags[i]) begin
          pos_comb = IDX_W'(i);
          stop     = 1'b1;
        end
      end
    end
    if (!use_affinity) begin
      pos_comb = '0;
    end
  end

  logic full, rel_set, get_ok;
  assign full    = entry_count >= CNT_W'(QUEUE_DEPTH);
  assign rel_set = in_use && release_flags[worker_q];
  assign get_ok  = in_use && blocking_id == abtd_pkg::AFF_NONE &&
                   (entry_count != '0 || rel_set);

  logic [ENT_W-1:0] taken;
  assign taken = slot_entry[pos_q];

  // the search flag; set once the slot is registered
  logic phase;

  // cell controls are driven in the update cycle only
  always_comb begin
    ctl.write = 1'b0;
    ctl.take  = 1'b0;
    if (state == abtd_pkg::S_SEARCH && phase) begin
      if (cmd_q == abtd_pkg::CMD_ADD && !full) ctl.write = 1'b1;
      if (cmd_q == abtd_pkg::CMD_GET && get_ok && entry_count != '0) ctl.take = 1'b1;
    end
  end

  abtd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W), .ENT_W(ENT_W)
  ) u_queue (
    .clk          (clk),
    .ctl          (ctl),
    .wr_slot      (entry_count[IDX_W-1:0]),
    .take_slot    (pos_q),
    .wr_entry     ({tag_q, aff_q, kind_q}),
    .want_aff     ({1'b0, worker_q}),
    .slot_entry   (slot_entry),
    .barrier_flags(barrier_flags),
    .match_flags  (match_flags)
  );

  // state sequencing: IDLE -> S_SEARCH (pos registered) -> S_OUT
  logic search_done;
  always_ff @(posedge clk) begin
    if (rst) state <= abtd_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      abtd_pkg::S_IDLE:   if (s_tvalid) state_next = abtd_pkg::S_SEARCH;
      abtd_pkg::S_SEARCH: if (search_done) state_next = abtd_pkg::S_OUT;
      abtd_pkg::S_OUT:    if (m_tready) state_next = abtd_pkg::S_IDLE;
      default:            state_next = abtd_pkg::S_IDLE;
    endcase
  end

  // the search is done once the slot is registered, then the update happens
  assign search_done = phase;

  logic [1:0]       r_status, r_gk;
  logic [4:0]       r_ga;
  logic [TAG_WIDTH-1:0] r_gt;
  logic             r_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= 1'b0;
      use_affinity    <= 1'b0;
      worker_count    <= 5'd16;
      entry_count     <= '0;
      blocking_id     <= abtd_pkg::AFF_NONE;
      busy_level      <= '0;
      release_flags   <= '0;
      delivered_total <= '0;
      completed_total <= '0;
      barrier_total   <= '0;
      emptied_total   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) use_affinity <= cfg_data[0];
        else                   worker_count <= cfg_data;
      end
      if (state == abtd_pkg::S_IDLE && s_tvalid) begin
        cmd_q    <= s_tdata[2:0];
        kind_q   <= s_tdata[4:3];
        aff_q    <= s_tdata[9:5];
        tag_q    <= s_tdata[10 +: TAG_WIDTH];
        worker_q <= s_tdata[10 + TAG_WIDTH +: 4];
        phase    <= 1'b0;
      end
      if (state == abtd_pkg::S_SEARCH && !phase) begin
        // hold the found slot for the update cycle
        pos_q <= pos_comb;
        phase <= 1'b1;
      end
      if (state == abtd_pkg::S_SEARCH && phase) begin
        phase    <= 1'b0;
        r_status <= abtd_pkg::ST_OK;
        r_gk     <= abtd_pkg::KIND_UNKNOWN;
        r_ga     <= abtd_pkg::AFF_NONE;
        r_gt     <= '0;
        r_done   <= 1'b0;
        case (cmd_q)
          abtd_pkg::CMD_ADD: begin
            if (full) r_status <= abtd_pkg::ST_FULL;
            else      entry_count <= entry_count + 1'b1;
          end
          abtd_pkg::CMD_GET: begin
            if (!get_ok) begin
              r_status <= abtd_pkg::ST_WAIT;
            end else begin
              if (entry_count != '0) begin
                r_gk <= taken[1:0];
                r_ga <= taken[6:2];
                r_gt <= taken[7 +: TAG_WIDTH];
                if (taken[1:0] == abtd_pkg::KIND_BARRIER) blocking_id <= {1'b0, worker_q};
                entry_count <= entry_count - 1'b1;
              end else begin
                r_status <= abtd_pkg::ST_NOOP;
                r_gk     <= abtd_pkg::KIND_NOOP;
              end
              if (busy_level < BUSY_W'(MAX_WORKERS)) busy_level <= busy_level + 1'b1;
              delivered_total <= delivered_total + 1'b1;
            end
          end
          abtd_pkg::CMD_COMPLETE: begin
            if (in_use) begin
              if (blocking_id == {1'b0, worker_q}) begin
                barrier_total <= barrier_total + 1'b1;
                blocking_id   <= abtd_pkg::AFF_NONE;
              end
              completed_total <= completed_total + 1'b1;
              if (busy_level != '0) busy_level <= busy_level - 1'b1;
              if (busy_level <= BUSY_W'(1) && entry_count == '0) begin
                emptied_total <= emptied_total + 1'b1;
                r_done        <= 1'b1;
              end
            end
          end
          abtd_pkg::CMD_REL_ALL: begin
            for (int i = 0; i < MAX_WORKERS; i++)
              if (7'(i) < active) release_flags[i] <= 1'b1;
          end
          abtd_pkg::CMD_REL_ONE: begin
            if (in_use) release_flags[worker_q] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign m_tvalid = (state == abtd_pkg::S_OUT);
  assign m_tdata = {
    3'd0,
    emptied_total, barrier_total, completed_total, delivered_total,
    (blocking_id != abtd_pkg::AFF_NONE),
    5'(entry_count), 5'(busy_level), r_done,
    16'(r_gt), r_ga, r_gk, r_status
  };

  // a result is never shown while the search phase is still open
  a_out_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !phase) else $error("result shown mid search");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    busy_level <= BUSY_W'(MAX_WORKERS)) else $error("busy count overflow");

endmodule

// ----- rtl/abtd_cell.sv -----
// ----------------------------------------------------------------------------
// abtd_cell: one slot of the task queue
// Holds one task, loads a new one, or takes the entry of its upper neighbor.
// Also forms the per-slot barrier flag and the match flag for the affinity search.
// ----------------------------------------------------------------------------
module abtd_cell #(
  parameter int ENT_W     = 23
) (
  input  logic                        clk,
  input  abtd_pkg::cell_ctl_t         ctl,
  input  logic                        load_here,
  input  logic                        shift_here,
  input  logic [ENT_W-1:0]            load_entry,
  input  logic [ENT_W-1:0]            upper_entry,
  input  logic [abtd_pkg::AFF_W-1:0]  want_aff,
  output logic [ENT_W-1:0]            entry,
  output logic                        is_barrier,
  output logic                        is_match
);

  logic [ENT_W-1:0] entry_q;

  always_ff @(posedge clk) begin
    if (ctl.write && load_here) begin
      entry_q <= load_entry;
    end else if (ctl.take && shift_here) begin
      entry_q <= upper_entry;
    end
  end

  assign entry      = entry_q;
  // entry layout: {tag, affinity, kind}
  assign is_barrier = entry_q[abtd_pkg::KIND_W-1:0] == abtd_pkg::KIND_BARRIER;
  assign is_match   = entry_q[abtd_pkg::KIND_W +: abtd_pkg::AFF_W] == want_aff;

endmodule

// ----- rtl/abtd_queue.sv -----
// ----------------------------------------------------------------------------
// abtd_queue: row of queue cells
// Appends at the tail, removes at any slot with a one-step shift toward head.
// Reports the per-slot barrier and match flags.
// ----------------------------------------------------------------------------
module abtd_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX_W       = 4,
  parameter int ENT_W       = 23
) (
  input  logic                        clk,
  input  abtd_pkg::cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]            wr_slot,
  input  logic [IDX_W-1:0]            take_slot,
  input  logic [ENT_W-1:0]            wr_entry,
  input  logic [abtd_pkg::AFF_W-1:0]  want_aff,
  output logic [ENT_W-1:0]            slot_entry [QUEUE_DEPTH],
  output logic [QUEUE_DEPTH-1:0]      barrier_flags,
  output logic [QUEUE_DEPTH-1:0]      match_flags
);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [ENT_W-1:0] upper;
      if (g == QUEUE_DEPTH - 1) begin : g_top
        assign upper = slot_entry[g];
      end else begin : g_mid
        assign upper = slot_entry[g+1];
      end
      abtd_cell #(.ENT_W(ENT_W)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .load_here  (wr_slot == IDX_W'(g)),
        .shift_here (IDX_W'(g) >= take_slot),
        .load_entry (wr_entry),
        .upper_entry(upper),
        .want_aff   (want_aff),
        .entry      (slot_entry[g]),
        .is_barrier (barrier_flags[g]),
        .is_match   (match_flags[g])
      );
    end
  endgenerate

endmodule

// ----- tb/tb_affinity_barrier_task_dispatcher_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affinity_barrier_task_dispatcher_top: self-checking bench of the dispatcher
// Drives a directed table of requests and then random traffic, predicts every
// result in a local model of the queue and compares it field by field.
// ----------------------------------------------------------------------------
module tb_affinity_barrier_task_dispatcher_top;

  localparam int DEPTH      = 16;
  localparam int NWORK      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam logic CFG_AFF  = 1'b0;
  localparam logic CFG_WCNT = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  aff;
    logic [15:0] tag;
  } task_t;

  // One result, same field order as m_tdata from the low bit up.
  typedef struct {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [4:0]  aff;
    logic [15:0] tag;
    logic        done;
    logic [4:0]  busy;
    logic [4:0]  qlen;
    logic        blocked;
    logic [31:0] delivered;
    logic [31:0] completed;
    logic [31:0] barriers;
    logic [31:0] emptied;
  } reply_t;

  // Directed row: request fields plus an optional typed-in status.
  typedef struct {
    logic [2:0]  cmd;
    logic [1:0]  kind;
    logic [4:0]  aff;
    logic [15:0] tag;
    logic [3:0]  worker;
    logic        has_status;
    logic [1:0]  status;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [4:0]   cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;

  affinity_barrier_task_dispatcher_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Predictor state
  task_t       queue_q[$];
  logic [4:0]  blocker;
  logic [4:0]  busy;
  logic [15:0] rel_flags;
  logic [31:0] n_delivered, n_completed, n_barriers, n_emptied;
  logic        aff_mode;
  logic [4:0]  wcount;

  reply_t      pending_q[$];
  logic        status_known_q[$];
  logic [1:0]  status_typed_q[$];

  int errors = 0;
  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_idle = 0;   // percent of cycles the receiver stalls
  int cycles = 0;

  function automatic int active_workers();
    return (wcount > NWORK) ? NWORK : wcount;
  endfunction

  // Advance the model by one request and return its reply.
  function automatic reply_t dispatch_step(logic [2:0] cmd, logic [1:0] kind,
                                           logic [4:0] aff, logic [15:0] tag,
                                           logic [3:0] w);
    reply_t r;
    bit     in_use;
    int     pos;
    task_t  t;
    in_use = (w < active_workers());
    r.status = abtd_pkg::ST_OK; r.kind = abtd_pkg::KIND_UNKNOWN;
    r.aff = abtd_pkg::AFF_NONE; r.tag = '0; r.done = 1'b0;
    case (cmd)
      abtd_pkg::CMD_ADD: begin
        if (queue_q.size() >= DEPTH) r.status = abtd_pkg::ST_FULL;
        else queue_q.push_back('{kind, aff, tag});
      end
      abtd_pkg::CMD_GET: begin
        if (!in_use || blocker != abtd_pkg::AFF_NONE ||
            (queue_q.size() == 0 && !rel_flags[w])) begin
          r.status = abtd_pkg::ST_WAIT;
        end else begin
          if (queue_q.size() != 0) begin
            pos = 0;
            if (aff_mode) begin
              foreach (queue_q[i]) begin
                if (queue_q[i].kind == abtd_pkg::KIND_BARRIER) break;
                if (queue_q[i].aff == {1'b0, w}) begin
                  pos = i;
                  break;
                end
              end
            end
            t = queue_q[pos];
            queue_q.delete(pos);
            if (t.kind == abtd_pkg::KIND_BARRIER) blocker = {1'b0, w};
            r.kind = t.kind; r.aff = t.aff; r.tag = t.tag;
          end else begin
            r.status = abtd_pkg::ST_NOOP;
            r.kind = abtd_pkg::KIND_NOOP;
          end
          if (busy < NWORK) busy++;
          n_delivered++;
        end
      end
      abtd_pkg::CMD_COMPLETE: begin
        if (in_use) begin
          if (blocker == {1'b0, w}) begin
            n_barriers++;
            blocker = abtd_pkg::AFF_NONE;
          end
          n_completed++;
          if (busy > 0) busy--;
          if (busy == 0 && queue_q.size() == 0) begin
            n_emptied++;
            r.done = 1'b1;
          end
        end
      end
      abtd_pkg::CMD_REL_ALL: begin
        for (int i = 0; i < active_workers(); i++) rel_flags[i] = 1'b1;
      end
      abtd_pkg::CMD_REL_ONE: begin
        if (in_use) rel_flags[w] = 1'b0;
      end
      default: ;
    endcase
    r.busy = busy; r.qlen = 5'(queue_q.size());
    r.blocked = (blocker != abtd_pkg::AFF_NONE);
    r.delivered = n_delivered; r.completed = n_completed;
    r.barriers = n_barriers; r.emptied = n_emptied;
    return r;
  endfunction

  // Hand one request to the block; predict its reply on acceptance.
  task automatic send_request(logic [2:0] cmd, logic [1:0] kind, logic [4:0] aff,
                              logic [15:0] tag, logic [3:0] w,
                              bit has_status = 0,
                              logic [1:0] st = abtd_pkg::ST_OK);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b0, w, tag, aff, kind, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_q.push_back(dispatch_step(cmd, kind, aff, tag, w));
    status_known_q.push_back(has_status);
    status_typed_q.push_back(st);
    s_tvalid <= 1'b0;
    // the block is busy with this request anyway
    @(posedge clk);
  endtask

  // Hold until every reply has arrived, then let the pipe settle.
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AFF) aff_mode = val[0];
    else wcount = val;
    @(posedge clk);
  endtask

  // Receiver: random stalls, check each reply against the oldest prediction.
  always @(posedge clk) begin
    reply_t e;
    reply_t a;
    bit     known;
    logic [1:0] typed;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        a.status = m_tdata[1:0];     a.kind = m_tdata[3:2];
        a.aff = m_tdata[8:4];        a.tag = m_tdata[24:9];
        a.done = m_tdata[25];        a.busy = m_tdata[30:26];
        a.qlen = m_tdata[35:31];     a.blocked = m_tdata[36];
        a.delivered = m_tdata[68:37];  a.completed = m_tdata[100:69];
        a.barriers = m_tdata[132:101]; a.emptied = m_tdata[164:133];
        if (pending_q.size() == 0) begin
          $error("reply with nothing expected");
          errors++;
        end else begin
          e = pending_q.pop_front();
          known = status_known_q.pop_front();
          typed = status_typed_q.pop_front();
          if (known && typed != e.status) begin
            $error("status table %0d model %0d", typed, e.status);
            errors++;
          end
          if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++; end
          if (a.kind !== e.kind) begin
            $error("given_kind exp %0d got %0d", e.kind, a.kind); errors++; end
          if (a.aff !== e.aff) begin
            $error("given_affinity exp %0d got %0d", e.aff, a.aff); errors++; end
          if (a.tag !== e.tag) begin
            $error("given_tag exp %0d got %0d", e.tag, a.tag); errors++; end
          if (a.done !== e.done) begin
            $error("all_done exp %0d got %0d", e.done, a.done); errors++; end
          if (a.busy !== e.busy) begin
            $error("busy_count exp %0d got %0d", e.busy, a.busy); errors++; end
          if (a.qlen !== e.qlen) begin
            $error("queue_length exp %0d got %0d", e.qlen, a.qlen); errors++; end
          if (a.blocked !== e.blocked) begin
            $error("blocked_flag exp %0d got %0d", e.blocked, a.blocked); errors++; end
          if (a.delivered !== e.delivered) begin
            $error("delivered_count exp %0d got %0d", e.delivered, a.delivered);
            errors++;
          end
          if (a.completed !== e.completed) begin
            $error("completed_count exp %0d got %0d", e.completed, a.completed);
            errors++;
          end
          if (a.barriers !== e.barriers) begin
            $error("barrier_count exp %0d got %0d", e.barriers, a.barriers);
            errors++;
          end
          if (a.emptied !== e.emptied) begin
            $error("emptied_count exp %0d got %0d", e.emptied, a.emptied);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Random request with bias toward traffic that keeps the queue moving.
  task automatic random_request();
    logic [2:0]  cmd;
    logic [3:0]  w;
    logic [4:0]  aff;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 38) cmd = abtd_pkg::CMD_ADD;
    else if (pick < 70) cmd = abtd_pkg::CMD_GET;
    else if (pick < 90) cmd = abtd_pkg::CMD_COMPLETE;
    else if (pick < 94) cmd = abtd_pkg::CMD_REL_ALL;
    else if (pick < 98) cmd = abtd_pkg::CMD_REL_ONE;
    else cmd = 3'($urandom_range(7, 5));
    // Mostly workers in use, so affinity hits are common.
    w = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                 : 4'($urandom_range(active_workers() - 1));
    pick = $urandom_range(9);
    aff = (pick < 6) ? 5'($urandom_range(active_workers() - 1))
        : (pick < 8) ? abtd_pkg::AFF_NONE : 5'($urandom);
    send_request(cmd, 2'($urandom), aff, 16'($urandom), w);
  endtask

  row_t rows[$];

  initial begin
    blocker = abtd_pkg::AFF_NONE; busy = 0; rel_flags = '0;
    n_delivered = 0; n_completed = 0; n_barriers = 0; n_emptied = 0;
    aff_mode = 0; wcount = 16;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: status typed in where obvious, rest from the predictor.
    rows = '{
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd0,  1, abtd_pkg::ST_WAIT},
      '{abtd_pkg::CMD_COMPLETE, 2'd0, 5'd0,  16'h0000, 4'd15, 1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_REL_ALL,  2'd0, 5'd0,  16'h0000, 4'd0,  1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd15, 1, abtd_pkg::ST_NOOP},
      '{abtd_pkg::CMD_REL_ONE,  2'd0, 5'd0,  16'h0000, 4'd15, 1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd15, 1, abtd_pkg::ST_WAIT},
      '{abtd_pkg::CMD_ADD,      2'd1, 5'd3,  16'hFFFF, 4'd0,  1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_ADD,      2'd3, 5'd31, 16'h0000, 4'd0,  1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_ADD,      2'd2, 5'd16, 16'hA5A5, 4'd0,  1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_ADD,      2'd0, 5'd7,  16'h5A5A, 4'd15, 1, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd3,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd5,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd5,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd7,  1, abtd_pkg::ST_WAIT},
      '{abtd_pkg::CMD_COMPLETE, 2'd0, 5'd0,  16'h0000, 4'd5,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_GET,      2'd0, 5'd0,  16'h0000, 4'd7,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_COMPLETE, 2'd0, 5'd0,  16'h0000, 4'd3,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_COMPLETE, 2'd0, 5'd0,  16'h0000, 4'd7,  0, abtd_pkg::ST_OK},
      '{abtd_pkg::CMD_COMPLETE, 2'd0, 5'd0,  16'h0000, 4'd9,  0, abtd_pkg::ST_OK},
      '{3'd7,                   2'd3, 5'd31, 16'hFFFF, 4'd15, 1, abtd_pkg::ST_OK}
    };
    // rows: empty get waits, completion from idle drains, noop grant after
    // release, wait after the flag drops, odd affinity, barrier taken by
    // worker 5 blocks worker 7 until it completes, busy saturates at zero,
    // unused command answers ok
    foreach (rows[i])
      send_request(rows[i].cmd, rows[i].kind, rows[i].aff, rows[i].tag,
                   rows[i].worker, rows[i].has_status, rows[i].status);
    // Overfill: the seventeenth add must come back full.
    for (int i = 0; i < 17; i++)
      send_request(abtd_pkg::CMD_ADD, 2'd1, abtd_pkg::AFF_NONE, 16'(i), 4'd0, 1,
                   (i == 16) ? abtd_pkg::ST_FULL : abtd_pkg::ST_OK);
    drain();

    // Affinity search on, few workers: worker beyond count is ignored.
    write_reg(CFG_AFF, 5'd1);
    write_reg(CFG_WCNT, 5'd1);
    send_request(abtd_pkg::CMD_GET, 2'd0, 5'd0, 16'h0, 4'd1, 1, abtd_pkg::ST_WAIT);
    drain();

    // Three phases of idling, each under its own configuration.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 66 : 0;
      recv_idle = (ph == 0) ? 66 : (ph == 1) ? 17 : 0;
      case (ph)
        0: begin write_reg(CFG_AFF, 5'd1); write_reg(CFG_WCNT, 5'd4); end
        1: begin write_reg(CFG_AFF, 5'd0); write_reg(CFG_WCNT, 5'd16); end
        default: begin write_reg(CFG_AFF, 5'd1); write_reg(CFG_WCNT, 5'd31); end
      endcase
      for (int n = 0; n < 230; n++) begin
        random_request();
        // Hold off once until the result stream is empty.
        if (ph == 2 && n == 100) while (pending_q.size() != 0) @(posedge clk);
      end
      drain();
    end
    // Zero workers in use: every get waits.
    write_reg(CFG_WCNT, 5'd0);
    send_request(abtd_pkg::CMD_GET, 2'd0, 5'd0, 16'h0, 4'd0, 1, abtd_pkg::ST_WAIT);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/abtd_pkg.sv
rtl/abtd_cell.sv
rtl/abtd_queue.sv
rtl/affinity_barrier_task_dispatcher_top.sv
tb/tb_affinity_barrier_task_dispatcher_top.sv
